FILE: src/x86enc_pkg.sv
// shared types and constants for the x86-64 instruction encoder
`timescale 1ns / 1ps

package x86enc_pkg;

  // byte offsets and the write count are this wide
  localparam int OFFSET_BITS = 16;

  // buffer capacity after reset
  localparam logic [OFFSET_BITS-1:0] CAP_RESET = 16'd4096;

  // request codes
  typedef enum logic [4:0] {
    OP_MOV_RR   = 5'd0,
    OP_MOV_IMM  = 5'd1,
    OP_LOAD     = 5'd2,
    OP_STORE    = 5'd3,
    OP_ADD      = 5'd4,
    OP_SUB      = 5'd5,
    OP_AND      = 5'd6,
    OP_OR       = 5'd7,
    OP_XOR      = 5'd8,
    OP_IMUL     = 5'd9,
    OP_IDIV     = 5'd10,
    OP_SHL_IMM  = 5'd11,
    OP_SAR_IMM  = 5'd12,
    OP_SHL_CL   = 5'd13,
    OP_SAR_CL   = 5'd14,
    OP_CMP      = 5'd15,
    OP_TEST     = 5'd16,
    OP_JMP      = 5'd17,
    OP_JCC      = 5'd18,
    OP_SETCC    = 5'd19,
    OP_CALL     = 5'd20,
    OP_MOVZX    = 5'd21,
    OP_PUSH     = 5'd22,
    OP_POP      = 5'd23,
    OP_RET      = 5'd24,
    OP_CQO      = 5'd25,
    OP_PATCH    = 5'd26
  } op_t;

  // machine code bytes
  localparam logic [7:0] B_REX     = 8'h40;
  localparam logic [7:0] B_REX_B   = 8'h41;
  localparam logic [7:0] B_REX_W   = 8'h48;
  localparam logic [7:0] B_MOV_ST  = 8'h89;
  localparam logic [7:0] B_MOV_LD  = 8'h8B;
  localparam logic [7:0] B_MOV_IMM = 8'hB8;
  localparam logic [7:0] B_ESC     = 8'h0F;
  localparam logic [7:0] B_IMUL    = 8'hAF;
  localparam logic [7:0] B_MOVZX   = 8'hB6;
  localparam logic [7:0] B_GRP3    = 8'hF7;
  localparam logic [7:0] B_SHF_IMM = 8'hC1;
  localparam logic [7:0] B_SHF_CL  = 8'hD3;
  localparam logic [7:0] B_JMP     = 8'hE9;
  localparam logic [7:0] B_JCC     = 8'h80;
  localparam logic [7:0] B_SETCC   = 8'h90;
  localparam logic [7:0] B_GRP5    = 8'hFF;
  localparam logic [7:0] B_PUSH    = 8'h50;
  localparam logic [7:0] B_POP     = 8'h58;
  localparam logic [7:0] B_RET     = 8'hC3;
  localparam logic [7:0] B_CQO     = 8'h99;
  localparam logic [7:0] B_SIB     = 8'h24;
  localparam logic [7:0] B_ADD     = 8'h01;
  localparam logic [7:0] B_SUB     = 8'h29;
  localparam logic [7:0] B_AND     = 8'h21;
  localparam logic [7:0] B_OR      = 8'h09;
  localparam logic [7:0] B_XOR     = 8'h31;
  localparam logic [7:0] B_CMP     = 8'h39;
  localparam logic [7:0] B_TEST    = 8'h85;

  // one instruction request
  typedef struct packed {
    logic [4:0]         opcode;
    logic [3:0]         dst_reg;
    logic [3:0]         src_reg;
    logic [3:0]         base_reg;
    logic [3:0]         cond;
    logic signed [63:0] immediate;
    logic signed [31:0] displacement;
    logic [15:0]        patch_offset;
  } req_t;

  // one emitted code byte
  typedef struct packed {
    logic [7:0]             code_byte;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic                   last;
  } res_t;

  // classified request: leading single bytes, then one wide piece
  typedef struct packed {
    logic [31:0]            singles;   // byte 0 in the low bits
    logic [2:0]             n_single;  // 0 to 4
    logic [63:0]            wide;
    logic [3:0]             n_wide;    // 0, 4 or 8
    logic                   is_patch;
    logic [OFFSET_BITS-1:0] patch_offset;
  } desc_t;

endpackage

FILE: src/x86enc_front.sv
// front end: takes requests and classifies them into byte descriptors
`timescale 1ns / 1ps

module x86enc_front (
  input  logic                req_valid,
  output logic                req_ready,
  input  x86enc_pkg::req_t    req,
  output logic                push,
  output x86enc_pkg::desc_t   desc,
  input  logic                q_full
);

  function automatic logic [7:0] modrm(input logic [1:0] mode, input logic [2:0] reg_f,
                                       input logic [2:0] rm);
    modrm = {mode, reg_f, rm};
  endfunction

  function automatic logic [7:0] rex_byte(input logic w, input logic [3:0] r,
                                          input logic [3:0] b);
    rex_byte = x86enc_pkg::B_REX | {4'b0, w, r[3], 1'b0, b[3]};
  endfunction

  logic        pre;
  logic [7:0]  pre_byte;
  logic [23:0] body;
  logic [1:0]  body_n;
  logic [63:0] wide;
  logic [3:0]  wide_n;
  logic        is_patch;
  logic        plain;
  logic        sib;
  logic [7:0]  alu_b;

  // handshake: accept whenever the queue has room
  assign req_ready = !q_full;
  assign push      = req_valid && !q_full;

  // memory operand shape
  assign plain = (req.displacement == 32'sd0) && (req.base_reg[2:0] != 3'd5);
  assign sib   = (req.base_reg[2:0] == 3'd4);

  // two-operand ALU opcode
  always_comb begin
    unique case (req.opcode)
      x86enc_pkg::OP_SUB:  alu_b = x86enc_pkg::B_SUB;
      x86enc_pkg::OP_AND:  alu_b = x86enc_pkg::B_AND;
      x86enc_pkg::OP_OR:   alu_b = x86enc_pkg::B_OR;
      x86enc_pkg::OP_XOR:  alu_b = x86enc_pkg::B_XOR;
      x86enc_pkg::OP_CMP:  alu_b = x86enc_pkg::B_CMP;
      x86enc_pkg::OP_TEST: alu_b = x86enc_pkg::B_TEST;
      default:             alu_b = x86enc_pkg::B_ADD;
    endcase
  end

  // per-opcode prefix, body bytes and wide piece
  always_comb begin
    pre      = 1'b0;
    pre_byte = 8'h00;
    body     = 24'h0;
    body_n   = 2'd0;
    wide     = 64'h0;
    wide_n   = 4'd0;
    is_patch = 1'b0;
    unique case (req.opcode)
      x86enc_pkg::OP_MOV_RR, x86enc_pkg::OP_ADD, x86enc_pkg::OP_SUB,
      x86enc_pkg::OP_AND, x86enc_pkg::OP_OR, x86enc_pkg::OP_XOR,
      x86enc_pkg::OP_CMP, x86enc_pkg::OP_TEST: begin
        pre      = 1'b1;
        pre_byte = rex_byte(1'b1, req.src_reg, req.dst_reg);
        body     = {8'h00, modrm(2'd3, req.src_reg[2:0], req.dst_reg[2:0]),
                    (req.opcode == x86enc_pkg::OP_MOV_RR) ? x86enc_pkg::B_MOV_ST : alu_b};
        body_n   = 2'd2;
      end
      x86enc_pkg::OP_MOV_IMM: begin
        pre      = 1'b1;
        pre_byte = rex_byte(1'b1, 4'd0, req.dst_reg);
        body     = {16'h0, x86enc_pkg::B_MOV_IMM + {5'b0, req.dst_reg[2:0]}};
        body_n   = 2'd1;
        wide     = req.immediate;
        wide_n   = 4'd8;
      end
      x86enc_pkg::OP_LOAD, x86enc_pkg::OP_STORE: begin
        pre = 1'b1;
        if (req.opcode == x86enc_pkg::OP_LOAD) begin
          pre_byte = rex_byte(1'b1, req.dst_reg, req.base_reg);
          body[15:0] = {modrm(plain ? 2'd0 : 2'd2, req.dst_reg[2:0], req.base_reg[2:0]),
                        x86enc_pkg::B_MOV_LD};
        end else begin
          pre_byte = rex_byte(1'b1, req.src_reg, req.base_reg);
          body[15:0] = {modrm(plain ? 2'd0 : 2'd2, req.src_reg[2:0], req.base_reg[2:0]),
                        x86enc_pkg::B_MOV_ST};
        end
        body[23:16] = sib ? x86enc_pkg::B_SIB : 8'h00;
        body_n      = sib ? 2'd3 : 2'd2;
        if (!plain) begin
          wide   = {32'h0, req.displacement};
          wide_n = 4'd4;
        end
      end
      x86enc_pkg::OP_IMUL, x86enc_pkg::OP_MOVZX: begin
        pre      = 1'b1;
        pre_byte = rex_byte(1'b1, req.dst_reg, req.src_reg);
        body     = {modrm(2'd3, req.dst_reg[2:0], req.src_reg[2:0]),
                    (req.opcode == x86enc_pkg::OP_IMUL) ? x86enc_pkg::B_IMUL
                                                        : x86enc_pkg::B_MOVZX,
                    x86enc_pkg::B_ESC};
        body_n   = 2'd3;
      end
      x86enc_pkg::OP_IDIV: begin
        pre      = 1'b1;
        pre_byte = rex_byte(1'b1, 4'd0, req.src_reg);
        body     = {8'h00, modrm(2'd3, 3'd7, req.src_reg[2:0]), x86enc_pkg::B_GRP3};
        body_n   = 2'd2;
      end
      x86enc_pkg::OP_SHL_IMM, x86enc_pkg::OP_SAR_IMM: begin
        pre      = 1'b1;
        pre_byte = rex_byte(1'b1, 4'd0, req.dst_reg);
        body     = {req.immediate[7:0],
                    modrm(2'd3, (req.opcode == x86enc_pkg::OP_SHL_IMM) ? 3'd4 : 3'd7,
                          req.dst_reg[2:0]),
                    x86enc_pkg::B_SHF_IMM};
        body_n   = 2'd3;
      end
      x86enc_pkg::OP_SHL_CL, x86enc_pkg::OP_SAR_CL: begin
        pre      = 1'b1;
        pre_byte = rex_byte(1'b1, 4'd0, req.dst_reg);
        body     = {8'h00,
                    modrm(2'd3, (req.opcode == x86enc_pkg::OP_SHL_CL) ? 3'd4 : 3'd7,
                          req.dst_reg[2:0]),
                    x86enc_pkg::B_SHF_CL};
        body_n   = 2'd2;
      end
      x86enc_pkg::OP_JMP: begin
        body   = {16'h0, x86enc_pkg::B_JMP};
        body_n = 2'd1;
        wide   = {32'h0, req.displacement};
        wide_n = 4'd4;
      end
      x86enc_pkg::OP_JCC: begin
        body   = {8'h00, x86enc_pkg::B_JCC + {4'b0, req.cond}, x86enc_pkg::B_ESC};
        body_n = 2'd2;
        wide   = {32'h0, req.displacement};
        wide_n = 4'd4;
      end
      x86enc_pkg::OP_SETCC: begin
        // byte registers 4 to 7 need a bare rex
        pre      = (req.dst_reg >= 4'd4);
        pre_byte = x86enc_pkg::B_REX | {7'b0, req.dst_reg[3]};
        body     = {modrm(2'd3, 3'd0, req.dst_reg[2:0]),
                    x86enc_pkg::B_SETCC + {4'b0, req.cond}, x86enc_pkg::B_ESC};
        body_n   = 2'd3;
      end
      x86enc_pkg::OP_CALL: begin
        pre      = req.dst_reg[3];
        pre_byte = x86enc_pkg::B_REX_B;
        body     = {8'h00, modrm(2'd3, 3'd2, req.dst_reg[2:0]), x86enc_pkg::B_GRP5};
        body_n   = 2'd2;
      end
      x86enc_pkg::OP_PUSH, x86enc_pkg::OP_POP: begin
        pre      = req.dst_reg[3];
        pre_byte = x86enc_pkg::B_REX_B;
        body     = {16'h0, ((req.opcode == x86enc_pkg::OP_PUSH) ? x86enc_pkg::B_PUSH
                                                                : x86enc_pkg::B_POP)
                           + {5'b0, req.dst_reg[2:0]}};
        body_n   = 2'd1;
      end
      x86enc_pkg::OP_RET: begin
        body   = {16'h0, x86enc_pkg::B_RET};
        body_n = 2'd1;
      end
      x86enc_pkg::OP_CQO: begin
        body   = {8'h00, x86enc_pkg::B_CQO, x86enc_pkg::B_REX_W};
        body_n = 2'd2;
      end
      x86enc_pkg::OP_PATCH: begin
        is_patch = 1'b1;
        wide     = {32'h0, req.displacement};
        wide_n   = 4'd4;
      end
      default: begin
      end
    endcase
  end

  // descriptor assembly
  always_comb begin
    desc.singles      = pre ? {body, pre_byte} : {8'h00, body};
    desc.n_single     = {1'b0, body_n} + {2'b0, pre};
    desc.wide         = wide;
    desc.n_wide       = wide_n;
    desc.is_patch     = is_patch;
    desc.patch_offset = req.patch_offset;
  end

endmodule

FILE: src/x86enc_fifo.sv
// small descriptor queue between front and back
`timescale 1ns / 1ps

module x86enc_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  x86enc_pkg::desc_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output x86enc_pkg::desc_t rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  x86enc_pkg::desc_t mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign rdata   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: src/x86enc_back.sv
// back end: places bytes in the buffer and streams them out one per cycle while res_ready allows
`timescale 1ns / 1ps

module x86enc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  input  logic                q_valid,
  input  x86enc_pkg::desc_t   q_desc,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_ready,
  output x86enc_pkg::res_t    res
);

  localparam int OB = x86enc_pkg::OFFSET_BITS;

  logic [OB-1:0] cap;
  logic [OB-1:0] write_count;
  logic [95:0]   buf_q;
  logic [3:0]    cnt;
  logic [OB-1:0] off;

  logic [OB:0]   rem;
  logic          neg;
  logic [2:0]    k;
  logic [3:0]    need;
  logic          fits;
  logic          fits_p;
  logic [31:0]   sel;
  logic [95:0]   ld_buf;
  logic [3:0]    ld_cnt;
  logic [OB-1:0] ld_off;
  logic          emit;
  logic          load_ok;

  assign cfg_ready = 1'b1;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= x86enc_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      cap <= cfg_data;
    end
  end

  // room left and how much of the head descriptor fits
  assign rem    = {1'b0, cap} - {1'b0, write_count};
  assign neg    = rem[OB];
  assign need   = {1'b0, k} + q_desc.n_wide;
  assign fits   = !neg && (rem >= {{(OB-3){1'b0}}, need});
  assign fits_p = ({1'b0, q_desc.patch_offset} + (OB+1)'(4)) <= {1'b0, cap};

  always_comb begin
    if (neg) begin
      k = 3'd0;
    end else if (rem >= {{(OB-2){1'b0}}, q_desc.n_single}) begin
      k = q_desc.n_single;
    end else begin
      k = rem[2:0];
    end
  end

  // keep the leading singles that fit and add the wide piece if it fits; patches load it alone
  always_comb begin
    unique case (k)
      3'd0:    sel = 32'h0;
      3'd1:    sel = {24'h0, q_desc.singles[7:0]};
      3'd2:    sel = {16'h0, q_desc.singles[15:0]};
      3'd3:    sel = {8'h0, q_desc.singles[23:0]};
      default: sel = q_desc.singles;
    endcase
  end

  always_comb begin
    if (q_desc.is_patch) begin
      ld_buf = {32'h0, q_desc.wide};
      ld_cnt = fits_p ? 4'd4 : 4'd0;
      ld_off = q_desc.patch_offset;
    end else begin
      ld_buf = ({32'h0, q_desc.wide} << {k, 3'b000}) | {64'h0, sel};
      ld_cnt = {1'b0, k} + (fits ? q_desc.n_wide : 4'd0);
      ld_off = write_count;
    end
  end

  // byte moves to the output word; next descriptor loads as the last one leaves
  assign emit    = (cnt != 4'd0) && (!res_valid || res_ready);
  assign load_ok = (cnt == 4'd0) || ((cnt == 4'd1) && emit);
  assign pop     = load_ok && q_valid;

  // streaming state and write count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= 4'd0;
      write_count <= '0;
    end else begin
      if (pop) begin
        cnt <= ld_cnt;
        if (!q_desc.is_patch) begin
          write_count <= write_count + {{(OB-4){1'b0}}, ld_cnt};
        end
      end else if (emit) begin
        cnt <= cnt - 4'd1;
      end
    end
  end

  // shift buffer and offset counter
  always_ff @(posedge clk) begin
    if (pop) begin
      buf_q <= ld_buf;
      off   <= ld_off;
    end else if (emit) begin
      buf_q <= {8'h00, buf_q[95:8]};
      off   <= off + OB'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.code_byte   <= buf_q[7:0];
      res.byte_offset <= off;
      res.last        <= (cnt == 4'd1);
    end
  end

endmodule

FILE: src/x86_64_instruction_encoder.sv
// top level of the x86-64 instruction encoder
//
//   channel  signals                       word
//   req      req_valid, req_ready, req     one instruction request (req_t)
//   res      res_valid, res_ready, res     one code byte with offset and last (res_t)
//   cfg      cfg_valid, cfg_ready, cfg_data  buffer capacity, 16 bits
//
// one code byte leaves per cycle unless the res channel stalls; a request emits
// 0 to 10 bytes. requests are decoded combinationally into a queue as accepted;
// the byte shifter in the back end sets the rate and loads the next request as
// the final byte leaves.
// reset clears the queue, the write count and the output word, and sets the
// capacity to 4096. either side may stall without losing or repeating a word.
`timescale 1ns / 1ps

module x86_64_instruction_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  x86enc_pkg::req_t  req,
  output logic              res_valid,
  input  logic              res_ready,
  output x86enc_pkg::res_t  res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              pop;
  x86enc_pkg::desc_t desc_in;
  x86enc_pkg::desc_t desc_out;

  // classify requests
  x86enc_front u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .push      (push),
    .desc      (desc_in),
    .q_full    (q_full)
  );

  // descriptor queue
  x86enc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wdata   (desc_in),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .rdata   (desc_out)
  );

  // place and stream bytes
  x86enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_desc    (desc_out),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
